/* rtl/core/psrq_pkg.sv */
package psrq_pkg;

    localparam int KeyW = 32;
    localparam int IdW  = 8;

    localparam logic [2:0] PolicyFifo      = 3'd0;
    localparam logic [2:0] PolicyArrival   = 3'd1;
    localparam logic [2:0] PolicyPriority  = 3'd2;
    localparam logic [2:0] PolicyBurst     = 3'd3;
    localparam logic [2:0] PolicyRemaining = 3'd4;

    localparam logic OpInsert = 1'b0;
    localparam logic OpPop    = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  task_id;
        logic [31:0] arrival_time;
        logic [3:0]  task_priority;
        logic [15:0] burst_length;
        logic [15:0] cpu_time_left;
    } t_in_beat;

    typedef struct packed {
        logic       popped_valid;
        logic [7:0] popped_id;
        logic [7:0] head_id;
        logic       queue_empty;
        logic [4:0] occupancy;
        logic       insert_dropped;
    } t_out_beat;

    typedef struct packed {
        logic            valid;
        logic [IdW-1:0]  id;
        logic [KeyW-1:0] key;
    } t_slot;

    typedef struct packed {
        logic            ins;
        logic            pop;
        logic            fifo;
        logic [IdW-1:0]  id;
        logic [KeyW-1:0] key;
    } t_cell_cmd;

endpackage

/* rtl/core/psrq_cell.sv */
module psrq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psrq_pkg::t_cell_cmd  i_cmd,
    input  psrq_pkg::t_slot      i_left,
    input  psrq_pkg::t_slot      i_right,
    input  logic                 i_placed,
    output logic                 o_placed,
    output psrq_pkg::t_slot      o_slot,
    output psrq_pkg::t_slot      o_next
);

    logic                        r_valid;
    logic [psrq_pkg::IdW-1:0]    r_id;
    logic [psrq_pkg::KeyW-1:0]   r_key;
    logic                        w_here;
    psrq_pkg::t_slot             n_slot;

    assign o_slot = '{valid: r_valid, id: r_id, key: r_key};

    // new item lands in the first cell that is empty or holds a larger key
    assign w_here   = !r_valid || (!i_cmd.fifo && (r_key > i_cmd.key));
    assign o_placed = i_placed || w_here;

    always_comb begin
        n_slot = o_slot;
        if (i_cmd.pop) begin
            n_slot = i_right;
        end else if (i_cmd.ins) begin
            if (i_placed) begin
                n_slot = i_left;
            end else if (w_here) begin
                n_slot = '{valid: 1'b1, id: i_cmd.id, key: i_cmd.key};
            end
        end
    end

    assign o_next = n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_slot.id;
        r_key <= n_slot.key;
    end

endmodule

/* rtl/core/policy_sorted_ready_queue.sv */
// Channel  | Dir | Handshake                  | Payload
// in       | in  | i_in_valid / o_in_ready    | i_in_data  (insert or pop)
// out      | out | o_out_valid / i_out_ready  | o_out_data (one result per beat)
// cfg      | in  | i_cfg_we, no wait          | i_cfg_wdata (policy)
//
// One beat per cycle while results are taken; the result is registered on acceptance and appears in the next cycle.
// The insert position is found by a ripple through the cell row in that cycle.
// Reset (synchronous, active low) empties the queue and sets fifo policy.
// A pending result that is not taken holds o_in_ready low.
module policy_sorted_ready_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  psrq_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output psrq_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_wdata
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [2:0]                 r_policy;
    logic [CntW-1:0]            r_count;
    logic [CntW-1:0]            n_count;
    logic                       r_out_valid;
    psrq_pkg::t_out_beat        r_out;
    psrq_pkg::t_out_beat        n_out;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_nonempty;
    logic                       w_fifo;
    logic [psrq_pkg::KeyW-1:0]  w_key;
    psrq_pkg::t_cell_cmd        w_cmd;
    psrq_pkg::t_slot            w_slot [QUEUE_DEPTH];
    psrq_pkg::t_slot            w_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]       w_placed;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_full     = (r_count == CntW'(QUEUE_DEPTH));
    assign w_nonempty = (r_count != '0);

    always_comb begin
        w_fifo = 1'b0;
        case (r_policy)
            psrq_pkg::PolicyArrival:   w_key = i_in_data.arrival_time;
            psrq_pkg::PolicyPriority:  w_key = 32'(i_in_data.task_priority);
            psrq_pkg::PolicyBurst:     w_key = 32'(i_in_data.burst_length);
            psrq_pkg::PolicyRemaining: w_key = 32'(i_in_data.cpu_time_left);
            default: begin
                w_key  = '0;
                w_fifo = 1'b1;
            end
        endcase
    end

    assign w_cmd = '{
        ins:  w_accept && (i_in_data.opcode == psrq_pkg::OpInsert) && !w_full,
        pop:  w_accept && (i_in_data.opcode == psrq_pkg::OpPop) && w_nonempty,
        fifo: w_fifo,
        id:   i_in_data.task_id,
        key:  w_key
    };

    assign w_placed[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        psrq_pkg::t_slot w_left;
        psrq_pkg::t_slot w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_slot[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end
        psrq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_placed (w_placed[g]),
            .o_placed (w_placed[g+1]),
            .o_slot   (w_slot[g]),
            .o_next   (w_next[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.pop) begin
            n_count = r_count - CntW'(1);
        end else if (w_cmd.ins) begin
            n_count = r_count + CntW'(1);
        end
        n_out.popped_valid   = w_cmd.pop;
        n_out.popped_id      = w_cmd.pop ? w_slot[0].id : '0;
        n_out.head_id        = w_next[0].valid ? w_next[0].id : '0;
        n_out.queue_empty    = (n_count == '0);
        n_out.occupancy      = 5'(n_count);
        n_out.insert_dropped = (i_in_data.opcode == psrq_pkg::OpInsert) && w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= psrq_pkg::PolicyFifo;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule
